// File: rtl/ppd_pkg.sv
// shared types, constants and helpers of the ppm pulse decoder
package ppd_pkg;

  localparam int unsigned CHANNELS_DEF = 9;
  localparam int unsigned TIME_W       = 16;
  localparam int unsigned SLOT_W       = 4;
  localparam int unsigned REG_IDX_W    = 2;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // register indexes of the config port
  localparam logic [REG_IDX_W-1:0] REG_SYNC_THRESHOLD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_PULSE      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_PULSE      = 2'd2;

  localparam logic [TIME_W-1:0] SYNC_THRESHOLD_RST = 16'd5000;
  localparam logic [TIME_W-1:0] MIN_PULSE_RST      = 16'd1800;
  localparam logic [TIME_W-1:0] MAX_PULSE_RST      = 16'd4200;
  localparam logic [TIME_W-1:0] STORE_RST_LOW      = 16'd1800;
  localparam logic [TIME_W-1:0] STORE_RST_MID      = 16'd3000;

  typedef enum logic [1:0] {
    KIND_SYNC   = 2'd0,
    KIND_STORED = 2'd1,
    KIND_RANGE  = 2'd2,
    KIND_BEYOND = 2'd3
  } kind_e;

  typedef struct packed {
    logic [TIME_W-1:0] sync_threshold;
    logic [TIME_W-1:0] min_pulse;
    logic [TIME_W-1:0] max_pulse;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] interval;
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
  } item_t;

  // power-up contents of one channel store entry
  function automatic logic [TIME_W-1:0] store_reset_value(input int unsigned idx);
    logic [TIME_W-1:0] val;
    val = ((idx >= 1) && (idx <= 3)) ? STORE_RST_MID : STORE_RST_LOW;
    return val;
  endfunction

endpackage

// File: rtl/ppm_pulse_decoder.sv
// top level of the ppm pulse decoder: config registers, classifier, queue, store stage
//
//   channel | signals                           | direction | beat contents
//   --------+-----------------------------------+-----------+---------------------------------
//   cfg     | cfg_valid_i / cfg_ready_o         | in        | cfg_index_i, cfg_data_i
//   in      | in_valid_i / in_ready_o           | in        | edge_time_i
//   out     | out_valid_o / out_ready_i         | out       | interval_o, kind_o, slot_o,
//           |                                   |           | slot_value_o
//
// one edge per cycle sustained while out_ready_i stays high; a result passes
// through a queue entry and then the output register after its edge beat
// the front stage does the subtract and the four compares in the accept cycle,
// the back stage updates the channel store and loads the output register
// a two-beat queue separates the stages, so the input keeps flowing while a
// result waits; in_ready_o drops only when the queue is full
// reset clears the config to its defaults, the index and previous edge to zero,
// and reloads the channel store contents at once, no clearing pass
// the config port is always ready; writes to an unknown index are dropped
module ppm_pulse_decoder #(
  parameter int unsigned CHANNELS = ppd_pkg::CHANNELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config port
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ppd_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [ppd_pkg::TIME_W-1:0]    cfg_data_i,
  // edge beats
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ppd_pkg::TIME_W-1:0]    edge_time_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ppd_pkg::TIME_W-1:0]    interval_o,
  output logic [1:0]                    kind_o,
  output logic [ppd_pkg::SLOT_W-1:0]    slot_o,
  output logic [ppd_pkg::TIME_W-1:0]    slot_value_o
);

  ppd_pkg::cfg_t  cfg_q, cfg_d;
  logic           cfg_we;

  logic           push, q_full, q_valid, pop;
  ppd_pkg::item_t front_item, q_item;

  // config registers: the user must write them only while the datapath is idle; the block does not enforce it
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (cfg_index_i)
        ppd_pkg::REG_SYNC_THRESHOLD: cfg_d.sync_threshold = cfg_data_i;
        ppd_pkg::REG_MIN_PULSE:      cfg_d.min_pulse      = cfg_data_i;
        ppd_pkg::REG_MAX_PULSE:      cfg_d.max_pulse      = cfg_data_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_threshold <= ppd_pkg::SYNC_THRESHOLD_RST;
      cfg_q.min_pulse      <= ppd_pkg::MIN_PULSE_RST;
      cfg_q.max_pulse      <= ppd_pkg::MAX_PULSE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classify each edge and track the channel index
  ppd_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .edge_time_i (edge_time_i),
    .push_o      (push),
    .item_o      (front_item),
    .q_full_i    (q_full)
  );

  // decoupling queue
  ppd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // channel store and output register
  ppd_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .item_i       (q_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .interval_o   (interval_o),
    .kind_o       (kind_o),
    .slot_o       (slot_o),
    .slot_value_o (slot_value_o)
  );

endmodule

// File: rtl/ppd_front.sv
// front part: interval measurement, classification and channel index tracking
module ppd_front #(
  parameter int unsigned CHANNELS = ppd_pkg::CHANNELS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ppd_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ppd_pkg::TIME_W-1:0] edge_time_i,
  output logic                       push_o,
  output ppd_pkg::item_t             item_o,
  input  logic                       q_full_i
);

  localparam logic [ppd_pkg::SLOT_W-1:0] CH_LIMIT = ppd_pkg::SLOT_W'(CHANNELS);

  logic [ppd_pkg::TIME_W-1:0] prev_q, prev_d;
  logic [ppd_pkg::SLOT_W-1:0] idx_q, idx_d;
  logic [ppd_pkg::TIME_W-1:0] interval;
  logic                       is_sync, is_sat, in_window;
  ppd_pkg::kind_e             kind;

  assign in_ready_o = ~q_full_i;
  assign push_o     = in_valid_i & in_ready_o;

  // wraps modulo 2^16 by width
  assign interval  = edge_time_i - prev_q;
  assign is_sync   = interval > cfg_i.sync_threshold;
  assign is_sat    = idx_q >= CH_LIMIT;
  assign in_window = (interval >= cfg_i.min_pulse) && (interval <= cfg_i.max_pulse);

  always_comb begin
    idx_d  = idx_q;
    prev_d = prev_q;
    if (is_sync) begin
      kind = ppd_pkg::KIND_SYNC;
    end else if (is_sat) begin
      kind = ppd_pkg::KIND_BEYOND;
    end else if (in_window) begin
      kind = ppd_pkg::KIND_STORED;
    end else begin
      kind = ppd_pkg::KIND_RANGE;
    end
    if (push_o) begin
      prev_d = edge_time_i;
      if (is_sync) begin
        idx_d = '0;
      end else if (!is_sat) begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  assign item_o.interval = interval;
  assign item_o.kind     = kind;
  assign item_o.slot     = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      idx_q  <= '0;
    end else begin
      prev_q <= prev_d;
      idx_q  <= idx_d;
    end
  end

endmodule

// File: rtl/ppd_queue.sv
// small fifo between the classifier and the store stage
module ppd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ppd_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ppd_pkg::item_t item_o
);

  localparam int unsigned PTR_W = (ppd_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(ppd_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(ppd_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ppd_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ppd_pkg::QUEUE_DEPTH);

  ppd_pkg::item_t   mem_q [ppd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign full_o  = cnt_q == FULL_CNT;
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/ppd_back.sv
// back part: channel store update and registered result
module ppd_back #(
  parameter int unsigned CHANNELS = ppd_pkg::CHANNELS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  ppd_pkg::item_t             item_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ppd_pkg::TIME_W-1:0] interval_o,
  output logic [1:0]                 kind_o,
  output logic [ppd_pkg::SLOT_W-1:0] slot_o,
  output logic [ppd_pkg::TIME_W-1:0] slot_value_o
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [ppd_pkg::SLOT_W-1:0] CH_LIMIT = ppd_pkg::SLOT_W'(CHANNELS);

  logic [ppd_pkg::TIME_W-1:0] store_q [CHANNELS];
  logic [IDX_W-1:0]           addr;
  logic                       in_range, do_store;
  logic [ppd_pkg::TIME_W-1:0] value;

  logic                       valid_q, valid_d;
  logic [ppd_pkg::TIME_W-1:0] interval_q, value_q;
  logic [1:0]                 kind_q;
  logic [ppd_pkg::SLOT_W-1:0] slot_q;

  assign pop_o    = q_valid_i & (~valid_q | out_ready_i);
  assign addr     = item_i.slot[IDX_W-1:0];
  assign in_range = item_i.slot < CH_LIMIT;
  assign do_store = pop_o & (item_i.kind == ppd_pkg::KIND_STORED);

  // stored beats forward the new value, saturated slots read zero
  always_comb begin
    if (!in_range) begin
      value = '0;
    end else if (item_i.kind == ppd_pkg::KIND_STORED) begin
      value = item_i.interval;
    end else begin
      value = store_q[addr];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < CHANNELS; i++) begin
        store_q[i] <= ppd_pkg::store_reset_value(i);
      end
    end else if (do_store) begin
      store_q[addr] <= item_i.interval;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      interval_q <= item_i.interval;
      kind_q     <= item_i.kind;
      slot_q     <= item_i.slot;
      value_q    <= value;
    end
  end

  assign out_valid_o  = valid_q;
  assign interval_o   = interval_q;
  assign kind_o       = kind_q;
  assign slot_o       = slot_q;
  assign slot_value_o = value_q;

endmodule

// File: test/ppd_result_checker.sv
`timescale 1ns / 1ps
// result scoreboard for the ppm pulse decoder: predicts every result beat and compares it
module ppd_result_checker
  import ppd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [TIME_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [TIME_W-1:0]    edge_time_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [TIME_W-1:0]    interval_i,
  input  logic [1:0]           kind_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [TIME_W-1:0]    slot_value_i,
  output int                   err_count_o,
  output int                   pending_o
);

  typedef struct {
    logic [TIME_W-1:0] interval;
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] slot_value;
  } edge_result_t;

  logic [TIME_W-1:0] thr_sync;
  logic [TIME_W-1:0] thr_min;
  logic [TIME_W-1:0] thr_max;
  logic [TIME_W-1:0] last_edge;
  logic [SLOT_W-1:0] chan_idx;
  logic [TIME_W-1:0] chan_store [CHANNELS_DEF];

  edge_result_t expected_q [$];
  int           mismatches = 0;

  // classify one edge and update the predicted decoder state
  function automatic edge_result_t classify_edge(input logic [TIME_W-1:0] edge_time);
    edge_result_t      res;
    logic [TIME_W-1:0] gap;
    gap            = edge_time - last_edge;
    res.interval   = gap;
    res.slot       = chan_idx;
    res.slot_value = '0;
    if (gap > thr_sync) begin
      res.kind = KIND_SYNC;
      chan_idx = '0;
    end else if (res.slot >= CHANNELS_DEF) begin
      res.kind = KIND_BEYOND;
    end else if (gap >= thr_min && gap <= thr_max) begin
      res.kind             = KIND_STORED;
      chan_store[res.slot] = gap;
      chan_idx             = res.slot + 1'b1;
    end else begin
      res.kind = KIND_RANGE;
      chan_idx = res.slot + 1'b1;
    end
    if (res.slot < CHANNELS_DEF) res.slot_value = chan_store[res.slot];
    last_edge = edge_time;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    edge_result_t want;
    if (!rst_ni) begin
      thr_sync  = SYNC_THRESHOLD_RST;
      thr_min   = MIN_PULSE_RST;
      thr_max   = MAX_PULSE_RST;
      last_edge = '0;
      chan_idx  = '0;
      for (int i = 0; i < CHANNELS_DEF; i++) begin
        chan_store[i] = (i >= 1 && i <= 3) ? STORE_RST_MID : STORE_RST_LOW;
      end
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SYNC_THRESHOLD: thr_sync = cfg_data_i;
          REG_MIN_PULSE:      thr_min  = cfg_data_i;
          REG_MAX_PULSE:      thr_max  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(classify_edge(edge_time_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: interval %0d kind %0d slot %0d",
                 interval_i, kind_i, slot_i);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("interval", want.interval, interval_i);
          check_field("kind", TIME_W'(want.kind), TIME_W'(kind_i));
          check_field("slot", TIME_W'(want.slot), TIME_W'(slot_i));
          check_field("slot_value", want.slot_value, slot_value_i);
        end
      end
    end
    pending_o   <= expected_q.size();
    err_count_o <= mismatches;
  end

endmodule

// File: test/ppm_pulse_decoder_tb.sv
`timescale 1ns / 1ps
// top of the ppm pulse decoder testbench: clock, reset, edge and config stimulus, verdict
module ppm_pulse_decoder_tb;
  import ppd_pkg::*;

  // the register port decodes two bits, index 3 has no register behind it
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // cycles without any beat before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 2000;
  // extra wait after the last predicted result has come out, for margin
  localparam int unsigned SETTLE_CYCLES = 4;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index_i = '0;
  logic [TIME_W-1:0]    cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic [TIME_W-1:0]    edge_time_i = '0;
  logic                 out_ready_i = 1'b0;
  logic                 cfg_ready_o;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [TIME_W-1:0]    interval_o;
  logic [1:0]           kind_o;
  logic [SLOT_W-1:0]    slot_o;
  logic [TIME_W-1:0]    slot_value_o;

  int          err_count;
  int          pending;
  logic        stall_en     = 1'b0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;

  // stimulus-side bookkeeping, only used to shape the edge train
  bit                idle_en    = 1'b0;
  int unsigned       edges_sent = 0;
  logic [TIME_W-1:0] last_sent  = '0;
  logic [TIME_W-1:0] cur_sync   = SYNC_THRESHOLD_RST;
  logic [TIME_W-1:0] cur_min    = MIN_PULSE_RST;
  logic [TIME_W-1:0] cur_max    = MAX_PULSE_RST;

  ppm_pulse_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .edge_time_i  (edge_time_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .interval_o   (interval_o),
    .kind_o       (kind_o),
    .slot_o       (slot_o),
    .slot_value_o (slot_value_o)
  );

  ppd_result_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .edge_time_i  (edge_time_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .interval_i   (interval_o),
    .kind_i       (kind_o),
    .slot_i       (slot_o),
    .slot_value_i (slot_value_o),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // result side back-pressure: ready drops in bursts of random length
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (stall_en && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 7);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // hang detector: any beat on any channel restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("FAIL ppm_pulse_decoder");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one edge beat; valid stays up between back-to-back beats
  task automatic send_edge(input logic [TIME_W-1:0] stamp);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    edge_time_i <= stamp;
    do @(posedge clk_i); while (!in_ready_o);
    last_sent = stamp;
    edges_sent++;
  endtask

  // next edge a given number of timer ticks after the last one, wrapping at 16 bits
  task automatic send_gap(input logic [TIME_W-1:0] gap);
    send_edge(last_sent + gap);
  endtask

  // stop sending and wait until every predicted result has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // single register beat, valid left high for the caller to lower
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // reprogram all thresholds while the decoder is idle, plus a dropped write
  task automatic set_thresholds(input logic [TIME_W-1:0] sync_thr,
                                input logic [TIME_W-1:0] min_thr,
                                input logic [TIME_W-1:0] max_thr);
    drain();
    write_reg(REG_SYNC_THRESHOLD, sync_thr);
    write_reg(REG_UNUSED, TIME_W'($urandom));
    write_reg(REG_MIN_PULSE, min_thr);
    write_reg(REG_MAX_PULSE, max_thr);
    cfg_valid_i <= 1'b0;
    cur_sync = sync_thr;
    cur_min  = min_thr;
    cur_max  = max_thr;
  endtask

  // gap inside the accept window and not above sync; anything non-sync if no such gap exists
  function automatic logic [TIME_W-1:0] pulse_gap();
    int unsigned lo;
    int unsigned hi;
    lo = cur_min;
    hi = (cur_max < cur_sync) ? cur_max : cur_sync;
    if (lo > hi) return TIME_W'($urandom_range(0, cur_sync));
    return TIME_W'($urandom_range(hi, lo));
  endfunction

  // one ppm frame: sync gap (any gap when no sync is possible) then a random number of channel pulses,
  // sometimes past the channel count and sometimes with bad pulses mixed in
  task automatic run_frame();
    int unsigned pulses;
    int unsigned pick;
    pulses = $urandom_range(0, CHANNELS_DEF + 3);
    if (cur_sync != '1) send_gap(TIME_W'($urandom_range(32'hFFFF, int'(cur_sync) + 1)));
    else send_gap(TIME_W'($urandom));
    repeat (pulses) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) send_gap(pulse_gap());
      else if (pick == 8) send_gap(TIME_W'($urandom_range(0, cur_sync)));
      else send_gap(TIME_W'($urandom));
    end
  endtask

  // mostly well-formed frames, some raw timestamps and the odd full drain
  task automatic random_phase(input int unsigned count, input bit idle);
    int unsigned stop_at;
    int unsigned pick;
    stop_at  = edges_sent + count;
    idle_en  = idle;
    stall_en <= idle;
    while (edges_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) run_frame();
      else if (pick < 98) send_edge(TIME_W'($urandom));
      else drain();
    end
  endtask

  initial begin
    logic [TIME_W-1:0] rs;
    logic [TIME_W-1:0] rmin;
    logic [TIME_W-1:0] rmax;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_en  = 1'b1;
    stall_en <= 1'b1;

    // directed part under the reset thresholds
    send_edge('0);               // same stamp as the reset edge, zero interval
    send_gap(16'd1799);          // just under the window, reset store value shows
    send_gap(16'd4201);          // just over the window
    send_gap(SYNC_THRESHOLD_RST); // equal to threshold is not a sync
    send_gap(16'd5001);          // first sync gap
    send_gap(MIN_PULSE_RST);     // window edges are stored
    send_gap(MAX_PULSE_RST);
    repeat (CHANNELS_DEF - 2) send_gap(16'd3000);
    send_gap(16'd2000);          // index saturated, in-window pulse dropped
    send_gap(16'd100);           // saturated and out of range
    send_gap(16'hFFFF);          // largest interval, sync while saturated
    send_edge(16'hFFFF);
    send_gap(16'd2000);          // timer wraps through zero
    send_edge(16'hAAAA);
    send_edge(16'h5555);

    // extreme settings: no sync possible and everything accepted
    set_thresholds(16'hFFFF, 16'h0000, 16'hFFFF);
    random_phase(150, 1'b1);
    // every nonzero interval is a sync, window is a single point
    set_thresholds(16'h0000, 16'h0000, 16'h0000);
    random_phase(100, 1'b1);
    // empty accept window
    set_thresholds(SYNC_THRESHOLD_RST, 16'd4000, 16'd1000);
    random_phase(150, 1'b1);

    // random settings, with and without idling
    repeat (4) begin
      rs   = TIME_W'($urandom_range(3000, 60000));
      rmin = TIME_W'($urandom_range(0, rs));
      rmax = TIME_W'($urandom_range(rmin, rs));
      set_thresholds(rs, rmin, rmax);
      random_phase(200, 1'(($urandom_range(0, 1))));
    end

    // back to the reset settings, last stretch runs at full rate
    set_thresholds(SYNC_THRESHOLD_RST, MIN_PULSE_RST, MAX_PULSE_RST);
    random_phase(200, 1'b1);
    random_phase(200, 1'b0);

    drain();
    if (err_count == 0 && pending == 0) begin
      $display("PASS ppm_pulse_decoder");
    end else begin
      $display("FAIL ppm_pulse_decoder");
    end
    $finish;
  end

endmodule

// File: ppm_pulse_decoder.f
rtl/ppd_pkg.sv
rtl/ppd_front.sv
rtl/ppd_queue.sv
rtl/ppd_back.sv
rtl/ppm_pulse_decoder.sv
test/ppd_result_checker.sv
test/ppm_pulse_decoder_tb.sv
